// File: design/wmp_pkg.sv
// Package for the window max pooling block: field widths, reset values,
// register and action codes, controller states and the control structs.
// No dependencies.
package wmp_pkg;

    // Default store geometry and window limit.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_WINDOW = 8;

    // Widths of the payload fields.
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int VALUE_W = 16;
    localparam int PLANE_W = 16;
    localparam int IDX_W   = 33;

    // Configuration register widths.
    localparam int DIM_W      = 9;
    localparam int WIN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Signed window coordinate: row * stride - pad / 2 + offset in window.
    localparam int POS_W = 14;

    localparam logic [DIM_W-1:0] RST_IN_WIDTH    = 9'd256;
    localparam logic [DIM_W-1:0] RST_IN_HEIGHT   = 9'd256;
    localparam logic [WIN_W-1:0] RST_WINDOW_SIZE = 4'd2;
    localparam logic [WIN_W-1:0] RST_STRIDE      = 4'd2;
    localparam logic [WIN_W-1:0] RST_PAD         = 4'd0;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH    = 3'd0,
        CFG_IN_HEIGHT   = 3'd1,
        CFG_WINDOW_SIZE = 3'd2,
        CFG_STRIDE      = 3'd3,
        CFG_PAD         = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PLANE,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic write_px;
        logic load_query;
        logic setup_mul;
        logic setup_plane;
        logic scan_init;
        logic scan_step;
        logic capture_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic size_zero;
        logic out_free;
    } t_dp_sts;

endpackage

// File: design/window_max_pool_with_index.sv
// Top level of the window max pooling block with argmax index.
// Depends on wmp_pkg, wmp_ctrl, wmp_datapath and wmp_ram.
//
//   Channel  Handshake                  Beat contents
//   input    i_in_valid / o_in_stall    i_action, i_row, i_col, i_sample, i_plane
//   output   o_out_valid / i_out_stall  o_max_value, o_max_index
//   config   i_cfg_we                   i_cfg_index, i_cfg_data
//
// A pixel write is accepted in ST_IDLE. A query steps through ST_MUL, ST_PLANE,
// ST_INIT, the window scan, ST_DRAIN and ST_RESULT (no scan or drain when the
// window size is zero); the single store read port gives one window pixel per cycle.
// Reset loads the register defaults; the pixel store is not cleared.
// A finished result waits in the output register; writes and the next query
// are accepted meanwhile, and that query holds before its result if needed.
module window_max_pool_with_index #(
    parameter int MAX_WIDTH  = wmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wmp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = wmp_pkg::DEF_MAX_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [wmp_pkg::ROW_W-1:0]           i_row,
    input  logic [wmp_pkg::COL_W-1:0]           i_col,
    input  logic signed [wmp_pkg::VALUE_W-1:0]  i_sample,
    input  logic [wmp_pkg::PLANE_W-1:0]         i_plane,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [wmp_pkg::VALUE_W-1:0]  o_max_value,
    output logic signed [wmp_pkg::IDX_W-1:0]    o_max_index,
    input  logic                                i_cfg_we,
    input  logic [wmp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wmp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import wmp_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    wmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    wmp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_sample    (i_sample),
        .i_plane     (i_plane),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_max_value (o_max_value),
        .o_max_index (o_max_index)
    );

    // A new result must never overwrite one that is still held.
    a_capture_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.capture_out |-> (!o_out_valid || !i_out_stall))
        else $error("result captured while the output register is held");

    // An accepted query occupies the block on the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_action == ACT_QUERY)) |=> o_in_stall)
        else $error("input not stalled after a query beat");

    // Output valid only rises after the controller captured a result.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.capture_out))
        else $error("output valid rose without a captured result");

endmodule

// File: design/wmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/wmp_ctrl.sv
// Controller of the window max pooling block: issues pixel writes, sequences setup,
// window scan and result hand-off. Depends on wmp_pkg.
module wmp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    output logic             o_in_stall,
    input  wmp_pkg::t_dp_sts i_sts,
    output wmp_pkg::t_dp_cmd o_cmd
);
    import wmp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == ACT_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_state          = ST_MUL;
                    end else begin
                        o_cmd.write_px = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.setup_mul = 1'b1;
                n_state         = ST_PLANE;
            end
            ST_PLANE: begin
                o_cmd.setup_plane = 1'b1;
                n_state           = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = i_sts.size_zero ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last pixel read is compared during this cycle.
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.capture_out = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/wmp_datapath.sv
// Datapath of the window max pooling block: configuration registers, pixel
// store, window address generation, running maximum and output register.
// Depends on wmp_pkg and wmp_ram.
module wmp_datapath #(
    parameter int MAX_WIDTH  = wmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wmp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WINDOW = wmp_pkg::DEF_MAX_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wmp_pkg::t_dp_cmd                    i_cmd,
    output wmp_pkg::t_dp_sts                    o_sts,
    input  logic                                i_cfg_we,
    input  logic [wmp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wmp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [wmp_pkg::ROW_W-1:0]           i_row,
    input  logic [wmp_pkg::COL_W-1:0]           i_col,
    input  logic signed [wmp_pkg::VALUE_W-1:0]  i_sample,
    input  logic [wmp_pkg::PLANE_W-1:0]         i_plane,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [wmp_pkg::VALUE_W-1:0]  o_max_value,
    output logic signed [wmp_pkg::IDX_W-1:0]    o_max_index
);
    import wmp_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FULL_W = ADDR_W + 9;
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_W   = $clog2(MAX_WINDOW + 1);
    localparam int WH_MAX = (W_W > H_W) ? W_W : H_W;
    localparam int DCMP_W = (WH_MAX > DIM_W) ? WH_MAX : DIM_W;
    localparam int SCMP_W = (SZ_W > WIN_W) ? SZ_W : WIN_W;
    localparam int PU_W   = POS_W - 1;

    // Configuration registers.
    logic [DIM_W-1:0] r_in_width;
    logic [DIM_W-1:0] r_in_height;
    logic [WIN_W-1:0] r_window_size;
    logic [WIN_W-1:0] r_stride;
    logic [WIN_W-1:0] r_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width    <= RST_IN_WIDTH;
            r_in_height   <= RST_IN_HEIGHT;
            r_window_size <= RST_WINDOW_SIZE;
            r_stride      <= RST_STRIDE;
            r_pad         <= RST_PAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IN_WIDTH:    r_in_width    <= i_cfg_data;
                CFG_IN_HEIGHT:   r_in_height   <= i_cfg_data;
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WIN_W-1:0];
                CFG_STRIDE:      r_stride      <= i_cfg_data[WIN_W-1:0];
                CFG_PAD:         r_pad         <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective plane size and window size, clamped to the store limits.
    logic [DCMP_W-1:0] w_cfg;
    logic [DCMP_W-1:0] h_cfg;
    logic [SCMP_W-1:0] s_cfg;
    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;
    logic [SZ_W-1:0]   size_eff;

    assign w_cfg = DCMP_W'(r_in_width);
    assign h_cfg = DCMP_W'(r_in_height);
    assign s_cfg = SCMP_W'(r_window_size);

    always_comb begin
        if (w_cfg == '0) begin
            w_eff = W_W'(1);
        end else if (w_cfg > DCMP_W'(MAX_WIDTH)) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(w_cfg);
        end
        if (h_cfg == '0) begin
            h_eff = H_W'(1);
        end else if (h_cfg > DCMP_W'(MAX_HEIGHT)) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(h_cfg);
        end
        if (s_cfg > SCMP_W'(MAX_WINDOW)) begin
            size_eff = SZ_W'(MAX_WINDOW);
        end else begin
            size_eff = SZ_W'(s_cfg);
        end
    end

    // Window origin: position times stride, minus half the padding.
    logic [ROW_W+WIN_W-1:0] row_prod;
    logic [COL_W+WIN_W-1:0] col_prod;
    logic [POS_W-1:0]       base_r_in;
    logic [POS_W-1:0]       base_c_in;

    assign row_prod  = i_row * r_stride;
    assign col_prod  = i_col * r_stride;
    assign base_r_in = POS_W'(row_prod) - POS_W'(r_pad[WIN_W-1:1]);
    assign base_c_in = POS_W'(col_prod) - POS_W'(r_pad[WIN_W-1:1]);

    // Query registers.
    logic [W_W-1:0]      r_w;
    logic [H_W-1:0]      r_h;
    logic [SZ_W-1:0]     r_size;
    logic [POS_W-1:0]    r_base_r;
    logic [POS_W-1:0]    r_base_c;
    logic [PLANE_W-1:0]  r_plane;
    logic [W_W+H_W-1:0]  r_wh;
    logic [IDX_W-1:0]    r_rw0;
    logic [IDX_W-1:0]    r_plane_base;
    logic [IDX_W-1:0]    r_row_idx;
    logic [SZ_W-1:0]     r_n;
    logic [SZ_W-1:0]     r_m;

    logic [W_W+H_W-1:0]           wh_prod;
    logic signed [POS_W+W_W:0]    rw_prod;
    logic [PLANE_W+W_W+H_W-1:0]   plane_prod;

    assign wh_prod    = r_w * r_h;
    assign rw_prod    = $signed(r_base_r) * $signed({1'b0, r_w});
    assign plane_prod = r_plane * r_wh;

    // Current window position and its bounds check.
    logic [POS_W-1:0]  pos_r;
    logic [POS_W-1:0]  pos_c;
    logic              r_ok;
    logic              c_ok;
    logic              pos_ok;
    logic              m_last;
    logic [ADDR_W-1:0] rd_addr;

    assign pos_r   = r_base_r + POS_W'(r_n);
    assign pos_c   = r_base_c + POS_W'(r_m);
    assign r_ok    = !pos_r[POS_W-1] && (pos_r[PU_W-1:0] < PU_W'(r_h));
    assign c_ok    = !pos_c[POS_W-1] && (pos_c[PU_W-1:0] < PU_W'(r_w));
    assign pos_ok  = r_ok && c_ok;
    assign m_last  = (r_m == r_size - SZ_W'(1));
    assign rd_addr = ADDR_W'(ADDR_W'(pos_r[PU_W-1:0]) * ADDR_W'(MAX_WIDTH))
                   + ADDR_W'(pos_c[PU_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_w      <= w_eff;
            r_h      <= h_eff;
            r_size   <= size_eff;
            r_base_r <= base_r_in;
            r_base_c <= base_c_in;
            r_plane  <= i_plane;
        end
        if (i_cmd.setup_mul) begin
            r_wh  <= wh_prod;
            r_rw0 <= IDX_W'(rw_prod);
        end
        if (i_cmd.setup_plane) begin
            r_plane_base <= IDX_W'(plane_prod);
        end
        if (i_cmd.scan_init) begin
            // Flat index of the first window row, modulo the index width.
            r_row_idx <= r_plane_base + r_rw0;
            r_n       <= '0;
            r_m       <= '0;
        end else if (i_cmd.scan_step) begin
            if (m_last) begin
                r_m       <= '0;
                r_n       <= r_n + SZ_W'(1);
                r_row_idx <= r_row_idx + IDX_W'(r_w);
            end else begin
                r_m <= r_m + SZ_W'(1);
            end
        end
    end

    // Pixel store.
    logic [FULL_W-1:0]  wr_full;
    logic               wr_we;
    logic [VALUE_W-1:0] rd_data;

    assign wr_full = FULL_W'(FULL_W'(i_row) * FULL_W'(MAX_WIDTH)) + FULL_W'(i_col);
    assign wr_we   = i_cmd.write_px && (wr_full < FULL_W'(DEPTH));

    wmp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_we),
        .i_waddr (ADDR_W'(wr_full)),
        .i_wdata (i_sample),
        .i_re    (i_cmd.scan_step && pos_ok),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Candidate stage: travels alongside the registered read.
    logic             r_cand_vld;
    logic [IDX_W-1:0] r_cand_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
        end else begin
            r_cand_vld <= i_cmd.scan_step && pos_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_idx <= r_row_idx + IDX_W'(pos_c[PU_W-1:0]);
    end

    // Running maximum; only a strictly greater pixel replaces it.
    logic signed [VALUE_W-1:0] r_best;
    logic                      r_found;
    logic [IDX_W-1:0]          r_best_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best  <= VALUE_MIN;
            r_found <= 1'b0;
        end else if (r_cand_vld && ($signed(rd_data) > r_best)) begin
            r_best     <= $signed(rd_data);
            r_found    <= 1'b1;
            r_best_idx <= r_cand_idx;
        end
    end

    // Output register.
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [IDX_W-1:0]          r_out_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.capture_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_out) begin
            r_out_value <= r_best;
            r_out_index <= r_found ? r_best_idx : '1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_max_value = r_out_value;
    assign o_max_index = $signed(r_out_index);

    assign o_sts.scan_last = m_last && (r_n == r_size - SZ_W'(1));
    assign o_sts.size_zero = (r_size == '0);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule
